@@ rtl/tksl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksl_pkg: shared types and codes for the top-K sorted insertion list
// Holds the item mode codes, register indexes, controller state encoding and
// the command bundle that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package tksl_pkg;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 5;
	localparam int CAP_REG_W   = 5;

	localparam logic [CFG_INDEX_W-1:0] REG_CAPACITY     = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_KEEP_HIGHEST = 1'b1;

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_READ   = 2'd1;
	localparam logic [1:0] MODE_CLEAR  = 2'd2;

	localparam logic [CAP_REG_W-1:0] CAPACITY_RESET = 5'd16;

	typedef enum logic [2:0] {
		ST_IDLE    = 3'b001,
		ST_COMPARE = 3'b010,
		ST_UPDATE  = 3'b100
	} state_t;

	typedef struct packed {
		logic load;
		logic compare;
		logic update;
	} ctrl_t;

endpackage

@@ rtl/top_k_sorted_insert_list.sv @@
`timescale 1ns / 1ps
// A transaction accepted at a clock edge passes through the compare and the update
// state of the sequencer; the done register then shows its result, with done high.
// A new transaction is accepted only after the last has left its update state;
// busy is low again in the cycle that carries done.
// The receiver cannot stall: each result is valid for exactly that one cycle.
// Reset: arst_n clears the fill count, the sequencer, done and the config registers.
// ----------------------------------------------------------------------------
// top_k_sorted_insert_list: bounded top-K insertion-sorted list
// Keeps up to capacity entries ordered by a signed fixed-point score with a
// small payload, and answers insert, read and clear transactions.
// ----------------------------------------------------------------------------
module top_k_sorted_insert_list #(
	parameter int K_MAX      = 16,
	parameter int SCORE_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Command channel.
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          mode,
	input  logic signed [SCORE_BITS-1:0]        score,
	input  logic [7:0]                          rule_index,
	input  logic signed [10:0]                  child_node,
	input  logic [7:0]                          child_length,
	input  logic [3:0]                          child_rank,
	input  logic [((K_MAX > 1) ? $clog2(K_MAX) : 1)-1:0] slot,
	// Configuration write port.
	input  logic                                cfg_wr_en,
	input  logic [tksl_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [tksl_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	// Result channel.
	output logic                                done,
	output logic                                accepted,
	output logic [$clog2(K_MAX+1)-1:0]          position,
	output logic [$clog2(K_MAX+1)-1:0]          entry_count,
	output logic                                read_valid,
	output logic signed [SCORE_BITS-1:0]        read_score,
	output logic [7:0]                          read_rule_index,
	output logic signed [10:0]                  read_child_node,
	output logic [7:0]                          read_child_length,
	output logic [3:0]                          read_child_rank
);

	// Count fields must hold K_MAX itself; the slot index only needs K_MAX places.
	localparam int CNT_W = $clog2(K_MAX + 1);
	localparam int IDX_W = (K_MAX > 1) ? $clog2(K_MAX) : 1;

	tksl_pkg::ctrl_t ctrl;

	// The sequencer walks each transaction through a compare cycle, in which every
	// cell compares its score with the new one, and an update cycle, in which the
	// insert position is picked and the cells below it shift down by one.
	tksl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.ctrl   (ctrl)
	);

	// The datapath holds the configuration registers, the row of entry cells,
	// the fill count and the registered result fields.
	tksl_dp #(
		.K_MAX      (K_MAX),
		.SCORE_BITS (SCORE_BITS),
		.CNT_W      (CNT_W),
		.IDX_W      (IDX_W)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.ctrl              (ctrl),
		.mode              (mode),
		.score             (score),
		.rule_index        (rule_index),
		.child_node        (child_node),
		.child_length      (child_length),
		.child_rank        (child_rank),
		.slot              (slot),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_index         (cfg_index),
		.cfg_wdata         (cfg_wdata),
		.done              (done),
		.accepted          (accepted),
		.position          (position),
		.entry_count       (entry_count),
		.read_valid        (read_valid),
		.read_score        (read_score),
		.read_rule_index   (read_rule_index),
		.read_child_node   (read_child_node),
		.read_child_length (read_child_length),
		.read_child_rank   (read_child_rank)
	);

	// An accepted transaction keeps the block busy in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	// A result only follows the update cycle of a transaction.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(ctrl.update))
		else $error("result strobe without an update cycle");

	// An inserted entry always lies inside the list that holds it.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && accepted) |-> (position < entry_count))
		else $error("insert position outside the held entries");

	// A dropped insert or any other transaction reports the out-of-range position.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && !accepted) |-> (position == CNT_W'(K_MAX)))
		else $error("position reported for a transaction that inserted nothing");

endmodule

@@ rtl/tksl_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksl_ctrl: transaction sequencer
// Steps each accepted transaction through a compare cycle and an update cycle.
// ----------------------------------------------------------------------------
module tksl_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	output tksl_pkg::ctrl_t ctrl
);

	tksl_pkg::state_t state_q;
	tksl_pkg::state_t state_next;

	always_comb begin
		state_next = state_q;
		case (state_q)
			tksl_pkg::ST_IDLE: begin
				if (start) begin
					state_next = tksl_pkg::ST_COMPARE;
				end
			end
			tksl_pkg::ST_COMPARE: begin
				state_next = tksl_pkg::ST_UPDATE;
			end
			tksl_pkg::ST_UPDATE: begin
				state_next = tksl_pkg::ST_IDLE;
			end
			default: begin
				state_next = tksl_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tksl_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	assign busy         = (state_q != tksl_pkg::ST_IDLE);
	assign ctrl.load    = start && (state_q == tksl_pkg::ST_IDLE);
	assign ctrl.compare = (state_q == tksl_pkg::ST_COMPARE);
	assign ctrl.update  = (state_q == tksl_pkg::ST_UPDATE);

endmodule

@@ rtl/tksl_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksl_dp: list storage, comparators and result registers
// Holds the sorted entries as a row of cells, compares the new score against
// every cell at once, then inserts and shifts in a single update cycle.
// ----------------------------------------------------------------------------
module tksl_dp #(
	parameter int K_MAX      = 16,
	parameter int SCORE_BITS = 32,
	parameter int CNT_W      = 5,
	parameter int IDX_W      = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tksl_pkg::ctrl_t                     ctrl,
	input  logic [1:0]                          mode,
	input  logic signed [SCORE_BITS-1:0]        score,
	input  logic [7:0]                          rule_index,
	input  logic signed [10:0]                  child_node,
	input  logic [7:0]                          child_length,
	input  logic [3:0]                          child_rank,
	input  logic [IDX_W-1:0]                    slot,
	input  logic                                cfg_wr_en,
	input  logic [tksl_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [tksl_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	output logic                                done,
	output logic                                accepted,
	output logic [CNT_W-1:0]                    position,
	output logic [CNT_W-1:0]                    entry_count,
	output logic                                read_valid,
	output logic signed [SCORE_BITS-1:0]        read_score,
	output logic [7:0]                          read_rule_index,
	output logic signed [10:0]                  read_child_node,
	output logic [7:0]                          read_child_length,
	output logic [3:0]                          read_child_rank
);

	localparam int CAP_W = (CNT_W > tksl_pkg::CAP_REG_W) ? CNT_W : tksl_pkg::CAP_REG_W;

	// Configuration registers.
	logic [tksl_pkg::CAP_REG_W-1:0] capacity_q;
	logic                           keep_highest_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q     <= tksl_pkg::CAPACITY_RESET;
			keep_highest_q <= 1'b1;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				tksl_pkg::REG_CAPACITY:     capacity_q     <= cfg_wdata[tksl_pkg::CAP_REG_W-1:0];
				tksl_pkg::REG_KEEP_HIGHEST: keep_highest_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Captured transaction.
	logic [1:0]                   mode_q;
	logic signed [SCORE_BITS-1:0] score_q;
	logic [7:0]                   rule_q;
	logic signed [10:0]           node_q;
	logic [7:0]                   length_q;
	logic [3:0]                   rank_q;
	logic [IDX_W-1:0]             slot_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			mode_q   <= mode;
			score_q  <= score;
			rule_q   <= rule_index;
			node_q   <= child_node;
			length_q <= child_length;
			rank_q   <= child_rank;
			slot_q   <= slot;
		end
	end

	// Entry cells and fill count.
	logic signed [SCORE_BITS-1:0] ent_score_q  [K_MAX];
	logic [7:0]                   ent_rule_q   [K_MAX];
	logic signed [10:0]           ent_node_q   [K_MAX];
	logic [7:0]                   ent_length_q [K_MAX];
	logic [3:0]                   ent_rank_q   [K_MAX];
	logic [CNT_W-1:0]             held_q;

	// Compare cycle: one flag per held cell that the new score strictly beats.
	logic [K_MAX-1:0] better;
	logic [K_MAX-1:0] better_s1;

	always_comb begin
		for (int j = 0; j < K_MAX; j++) begin
			better[j] = (CNT_W'(j) < held_q) &&
				(keep_highest_q ? (score_q > ent_score_q[j]) : (score_q < ent_score_q[j]));
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.compare) begin
			better_s1 <= better;
		end
	end

	// Update cycle: the first beaten cell is the insert position.
	logic [CNT_W-1:0] pos;
	logic [CNT_W-1:0] cap_eff;
	logic [CNT_W-1:0] end_idx;
	logic             ins_ok;
	logic             rd_hit;
	logic [CNT_W-1:0] held_next;

	always_comb begin
		pos = held_q;
		for (int j = K_MAX - 1; j >= 0; j--) begin
			if (better_s1[j]) begin
				pos = CNT_W'(j);
			end
		end
	end

	assign cap_eff = (CAP_W'(capacity_q) > CAP_W'(K_MAX)) ? CNT_W'(K_MAX)
		: CNT_W'(CAP_W'(capacity_q));
	assign ins_ok  = (mode_q == tksl_pkg::MODE_INSERT) && (pos < cap_eff);
	assign end_idx = (held_q < cap_eff) ? held_q : (cap_eff - CNT_W'(1));
	assign rd_hit  = (mode_q == tksl_pkg::MODE_READ) && (CNT_W'(slot_q) < held_q);

	always_comb begin
		held_next = held_q;
		case (mode_q)
			tksl_pkg::MODE_INSERT: begin
				if (ins_ok && (held_q < cap_eff)) begin
					held_next = held_q + CNT_W'(1);
				end
			end
			tksl_pkg::MODE_CLEAR: begin
				held_next = '0;
			end
			default: begin
				held_next = held_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (ctrl.update) begin
			held_q <= held_next;
		end
	end

	for (genvar j = 0; j < K_MAX; j++) begin : g_cell
		logic signed [SCORE_BITS-1:0] src_score;
		logic [7:0]                   src_rule;
		logic signed [10:0]           src_node;
		logic [7:0]                   src_length;
		logic [3:0]                   src_rank;
		logic                         take_new;
		logic                         take_shift;

		if (j == 0) begin : g_head
			assign src_score  = score_q;
			assign src_rule   = rule_q;
			assign src_node   = node_q;
			assign src_length = length_q;
			assign src_rank   = rank_q;
		end else begin : g_body
			assign src_score  = ent_score_q[j-1];
			assign src_rule   = ent_rule_q[j-1];
			assign src_node   = ent_node_q[j-1];
			assign src_length = ent_length_q[j-1];
			assign src_rank   = ent_rank_q[j-1];
		end

		assign take_new   = ins_ok && (pos == CNT_W'(j));
		assign take_shift = ins_ok && (CNT_W'(j) > pos) && (CNT_W'(j) <= end_idx);

		always_ff @(posedge clk) begin
			if (ctrl.update) begin
				if (take_new) begin
					ent_score_q[j]  <= score_q;
					ent_rule_q[j]   <= rule_q;
					ent_node_q[j]   <= node_q;
					ent_length_q[j] <= length_q;
					ent_rank_q[j]   <= rank_q;
				end else if (take_shift) begin
					ent_score_q[j]  <= src_score;
					ent_rule_q[j]   <= src_rule;
					ent_node_q[j]   <= src_node;
					ent_length_q[j] <= src_length;
					ent_rank_q[j]   <= src_rank;
				end
			end
		end
	end

	// Result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctrl.update;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.update) begin
			accepted          <= ins_ok;
			position          <= ins_ok ? pos : CNT_W'(K_MAX);
			entry_count       <= held_next;
			read_valid        <= rd_hit;
			read_score        <= rd_hit ? ent_score_q[slot_q]  : '0;
			read_rule_index   <= rd_hit ? ent_rule_q[slot_q]   : '0;
			read_child_node   <= rd_hit ? ent_node_q[slot_q]   : '0;
			read_child_length <= rd_hit ? ent_length_q[slot_q] : '0;
			read_child_rank   <= rd_hit ? ent_rank_q[slot_q]   : '0;
		end
	end

endmodule

@@ tb/top_k_sorted_insert_list_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_sorted_insert_list_test: self-checking bench for the top-K insert list
// Drives insert, read, clear and unused-mode transactions through the command
// port. Each accepted transaction runs through a behavioral copy of the sorted
// list, and the expected answer is queued. Every done strobe is checked field
// by field against the oldest queued answer. Capacity and ordering are changed
// only while the block is idle, and cover zero, one, full size and values
// above the largest list size.
// ----------------------------------------------------------------------------
module top_k_sorted_insert_list_test;

	localparam int K_MAX       = 16;
	localparam int SCORE_BITS  = 32;
	localparam int COUNT_W     = 5;
	// The fourth mode code has no function; the list must ignore it.
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	// The result follows acceptance through the compare and update states and
	// the done register, so quiet cycles after the last done let the block idle.
	localparam int SETTLE_CYCLES = 4;
	// Cycles in a row with no transaction and no result before giving up.
	localparam int QUIET_LIMIT   = 500;
	localparam int PHASES        = 12;
	localparam int PHASE_ITEMS   = 138;

	// One word on the configuration data port.
	typedef logic [tksl_pkg::CFG_DATA_W-1:0] cfg_word_t;

	// One list slot as the bench models it.
	typedef struct packed {
		logic signed [SCORE_BITS-1:0] score;
		logic [7:0]                   rule_index;
		logic signed [10:0]           child_node;
		logic [7:0]                   child_length;
		logic [3:0]                   child_rank;
	} list_entry_t;

	// One command transaction.
	typedef struct packed {
		logic [1:0]                   mode;
		logic signed [SCORE_BITS-1:0] score;
		logic [7:0]                   rule_index;
		logic signed [10:0]           child_node;
		logic [7:0]                   child_length;
		logic [3:0]                   child_rank;
		logic [3:0]                   slot;
	} list_item_t;

	// One result transaction.
	typedef struct packed {
		logic                         accepted;
		logic [COUNT_W-1:0]           position;
		logic [COUNT_W-1:0]           entry_count;
		logic                         read_valid;
		logic signed [SCORE_BITS-1:0] read_score;
		logic [7:0]                   read_rule_index;
		logic signed [10:0]           read_child_node;
		logic [7:0]                   read_child_length;
		logic [3:0]                   read_child_rank;
	} list_result_t;

	logic                                 clk;
	logic                                 arst_n;
	logic                                 start;
	logic                                 busy;
	logic [1:0]                           mode;
	logic signed [SCORE_BITS-1:0]         score;
	logic [7:0]                           rule_index;
	logic signed [10:0]                   child_node;
	logic [7:0]                           child_length;
	logic [3:0]                           child_rank;
	logic [3:0]                           slot;
	logic                                 cfg_wr_en;
	logic [tksl_pkg::CFG_INDEX_W-1:0]     cfg_index;
	logic [tksl_pkg::CFG_DATA_W-1:0]      cfg_wdata;
	logic                                 done;
	logic                                 accepted;
	logic [COUNT_W-1:0]                   position;
	logic [COUNT_W-1:0]                   entry_count;
	logic                                 read_valid;
	logic signed [SCORE_BITS-1:0]         read_score;
	logic [7:0]                           read_rule_index;
	logic signed [10:0]                   read_child_node;
	logic [7:0]                           read_child_length;
	logic [3:0]                           read_child_rank;

	// Shadow of the list: slots, fill count and both registers.
	list_entry_t                        held_list [K_MAX];
	int                                 held_total;
	logic [tksl_pkg::CAP_REG_W-1:0]     cap_setting;
	bit                                 highest_first;

	// Answers owed by the block, oldest first.
	list_result_t expected_results [$];
	list_result_t want_result;
	int           mismatches;
	int           results_seen;
	// Cleared for the last phase so that back-to-back transactions are covered.
	bit           sender_idles;

	top_k_sorted_insert_list #(
		.K_MAX      (K_MAX),
		.SCORE_BITS (SCORE_BITS)
	) dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.mode              (mode),
		.score             (score),
		.rule_index        (rule_index),
		.child_node        (child_node),
		.child_length      (child_length),
		.child_rank        (child_rank),
		.slot              (slot),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_index         (cfg_index),
		.cfg_wdata         (cfg_wdata),
		.done              (done),
		.accepted          (accepted),
		.position          (position),
		.entry_count       (entry_count),
		.read_valid        (read_valid),
		.read_score        (read_score),
		.read_rule_index   (read_rule_index),
		.read_child_node   (read_child_node),
		.read_child_length (read_child_length),
		.read_child_rank   (read_child_rank)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Runs one transaction through the shadow list and returns the answer the
	// block must give for it.
	function automatic list_result_t apply_list_item(input list_item_t it);
		list_result_t res;
		int lim;
		int pos;
		int last;
		int j;
		res = '0;
		res.position = COUNT_W'(K_MAX);
		// Capacity values above the list size behave as the full size.
		lim = (int'(cap_setting) > K_MAX) ? K_MAX : int'(cap_setting);
		case (it.mode)
			tksl_pkg::MODE_INSERT: begin
				// The new entry goes in front of the first entry that it strictly
				// beats; scanning from the back leaves pos at that first one.
				pos = held_total;
				for (j = held_total - 1; j >= 0; j--) begin
					if (highest_first ? ($signed(it.score) > $signed(held_list[j].score))
							: ($signed(it.score) < $signed(held_list[j].score)))
						pos = j;
				end
				if (pos < lim) begin
					// When the count already reaches capacity (or stands above a
					// lowered capacity) the slot at capacity-1 is overwritten.
					last = (held_total < lim) ? held_total : lim - 1;
					for (j = last; j > pos; j--)
						held_list[j] = held_list[j - 1];
					held_list[pos].score        = it.score;
					held_list[pos].rule_index   = it.rule_index;
					held_list[pos].child_node   = it.child_node;
					held_list[pos].child_length = it.child_length;
					held_list[pos].child_rank   = it.child_rank;
					if (held_total < lim)
						held_total++;
					res.accepted = 1'b1;
					res.position = COUNT_W'(pos);
				end
			end
			tksl_pkg::MODE_READ: begin
				if (int'(it.slot) < held_total) begin
					res.read_valid        = 1'b1;
					res.read_score        = held_list[it.slot].score;
					res.read_rule_index   = held_list[it.slot].rule_index;
					res.read_child_node   = held_list[it.slot].child_node;
					res.read_child_length = held_list[it.slot].child_length;
					res.read_child_rank   = held_list[it.slot].child_rank;
				end
			end
			tksl_pkg::MODE_CLEAR: begin
				// Stored slots stay as they are; only the count drops.
				held_total = 0;
			end
			default: begin
			end
		endcase
		res.entry_count = COUNT_W'(held_total);
		return res;
	endfunction

	function automatic list_item_t rand_item();
		list_item_t it;
		it.mode         = 2'($urandom_range(0, 3));
		it.score        = $urandom;
		it.rule_index   = 8'($urandom);
		it.child_node   = 11'($urandom_range(0, 1024) - 1);
		it.child_length = 8'($urandom);
		it.child_rank   = 4'($urandom);
		it.slot         = 4'($urandom);
		return it;
	endfunction

	// Scores are drawn from the full range, from the extremes, and from a
	// coarse grid around zero so that equal scores meet often.
	function automatic logic signed [SCORE_BITS-1:0] rand_score();
		case ($urandom_range(0, 9))
			4: return 32'sh7FFF_FFFF;
			5: return 32'sh8000_0000;
			6: return 32'sh0000_0000;
			7: return -32'sd1;
			8, 9: return (32'($urandom_range(0, 7)) - 32'd4) << 16;
			default: return $urandom;
		endcase
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch on result %0d: %s is %h, expected %h",
			results_seen, field, got, want);
		mismatches++;
	endtask

	// Presents one transaction and returns at the edge that accepts it. Start
	// is left high so that a following transaction can go out back to back.
	task automatic send_list_item(input list_item_t it);
		if (sender_idles && $urandom_range(0, 5) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		start        <= 1'b1;
		mode         <= it.mode;
		score        <= it.score;
		rule_index   <= it.rule_index;
		child_node   <= it.child_node;
		child_length <= it.child_length;
		child_rank   <= it.child_rank;
		slot         <= it.slot;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		expected_results.push_back(apply_list_item(it));
	endtask

	task automatic insert_entry(input logic signed [SCORE_BITS-1:0] s,
			input logic [7:0] r, input logic signed [10:0] c, input logic [7:0] l,
			input logic [3:0] k);
		list_item_t it;
		it = rand_item();
		it.mode         = tksl_pkg::MODE_INSERT;
		it.score        = s;
		it.rule_index   = r;
		it.child_node   = c;
		it.child_length = l;
		it.child_rank   = k;
		send_list_item(it);
	endtask

	task automatic read_slot(input logic [3:0] s);
		list_item_t it;
		it = rand_item();
		it.mode = tksl_pkg::MODE_READ;
		it.slot = s;
		send_list_item(it);
	endtask

	task automatic send_mode(input logic [1:0] m);
		list_item_t it;
		it = rand_item();
		it.mode = m;
		send_list_item(it);
	endtask

	// Holds the sender back until every owed answer has come, then lets the
	// block finish any trailing cycles.
	task automatic settle_list();
		start <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes both registers while the block is idle. Only bit 0 of the
	// ordering value counts; the upper bits are free.
	task automatic configure_list(input cfg_word_t cap, input cfg_word_t order);
		settle_list();
		cfg_wr_en <= 1'b1;
		cfg_index <= tksl_pkg::REG_CAPACITY;
		cfg_wdata <= cap;
		@(posedge clk);
		cap_setting = cap[tksl_pkg::CAP_REG_W-1:0];
		cfg_index <= tksl_pkg::REG_KEEP_HIGHEST;
		cfg_wdata <= order;
		@(posedge clk);
		highest_first = order[0];
		cfg_wr_en <= 1'b0;
	endtask

	// Reset defaults: largest first, full capacity. Covers the empty read, the
	// score and payload extremes, a tie, the unused mode and reads on both
	// sides of the fill count.
	task automatic test_basic_order();
		int s;
		read_slot(4'd0);
		insert_entry(32'sh7FFF_FFFF, 8'hFF, -11'sd1, 8'hFF, 4'hF);
		insert_entry(32'sh8000_0000, 8'h00, 11'sd1023, 8'h00, 4'h0);
		insert_entry(32'sh0000_0000, 8'h11, 11'sd5, 8'h22, 4'h3);
		// An equal score must land behind the entry that already holds it.
		insert_entry(32'sh0000_0000, 8'h44, 11'sd6, 8'h55, 4'h6);
		insert_entry(-32'sd1, 8'h77, 11'sd7, 8'h88, 4'h9);
		send_mode(MODE_UNUSED);
		for (s = 0; s <= 5; s++)
			read_slot(4'(s));
		read_slot(4'd15);
	endtask

	// Capacity zero, capacity lowered under the fill count, capacity above the
	// list size with smallest-first ordering, and a clear.
	task automatic test_capacity_limits();
		configure_list(5'd0, 5'd1);
		insert_entry(32'sh7FFF_FFFF, 8'h01, 11'sd1, 8'h01, 4'h1);
		// Five entries held, capacity two: a winning insert overwrites slot one
		// without growing the count, a losing one is dropped, and the slots past
		// capacity remain readable.
		configure_list(5'd2, 5'd1);
		insert_entry(32'sh4000_0000, 8'h5A, 11'sd300, 8'hA5, 4'h5);
		insert_entry(32'sh0000_0000, 8'h66, 11'sd66, 8'h66, 4'h6);
		read_slot(4'd4);
		configure_list(5'd31, 5'd0);
		insert_entry(32'sh8000_0000, 8'hC3, -11'sd1, 8'h3C, 4'hC);
		read_slot(4'd0);
		send_mode(tksl_pkg::MODE_CLEAR);
		read_slot(4'd0);
	endtask

	// Phases of random traffic, each under its own capacity and ordering. The
	// list is not cleared between phases, so lowered capacities meet full lists.
	task automatic test_random_traffic();
		cfg_word_t  phase_caps [PHASES];
		list_item_t it;
		int ph;
		int n;
		int pick;
		phase_caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd16, 5'd2, 5'd17, 5'd9,
			5'd16, 5'd12, 5'd16};
		for (ph = 0; ph < PHASES; ph++) begin
			configure_list(phase_caps[ph],
				cfg_word_t'(($urandom_range(0, 15) << 1) | (ph & 1)));
			sender_idles = (ph < PHASES - 1);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				it = rand_item();
				it.score = rand_score();
				pick = $urandom_range(0, 99);
				if (pick < 60)
					it.mode = tksl_pkg::MODE_INSERT;
				else if (pick < 96)
					it.mode = tksl_pkg::MODE_READ;
				else if (pick < 98)
					it.mode = tksl_pkg::MODE_CLEAR;
				else
					it.mode = MODE_UNUSED;
				send_list_item(it);
			end
		end
	endtask

	// Every done strobe is one result transaction; it is matched against the
	// oldest owed answer. Outputs are sampled at the edge that ends the cycle.
	always @(posedge clk) begin
		if (arst_n && done) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				report_mismatch("done with nothing owed", 32'd1, 32'd0);
			end else begin
				want_result = expected_results.pop_front();
				if (accepted !== want_result.accepted)
					report_mismatch("accepted", accepted, want_result.accepted);
				if (position !== want_result.position)
					report_mismatch("position", position, want_result.position);
				if (entry_count !== want_result.entry_count)
					report_mismatch("entry_count", entry_count, want_result.entry_count);
				if (read_valid !== want_result.read_valid)
					report_mismatch("read_valid", read_valid, want_result.read_valid);
				if (read_score !== want_result.read_score)
					report_mismatch("read_score", read_score, want_result.read_score);
				if (read_rule_index !== want_result.read_rule_index)
					report_mismatch("read_rule_index", read_rule_index,
						want_result.read_rule_index);
				if (read_child_node !== want_result.read_child_node)
					report_mismatch("read_child_node", read_child_node,
						want_result.read_child_node);
				if (read_child_length !== want_result.read_child_length)
					report_mismatch("read_child_length", read_child_length,
						want_result.read_child_length);
				if (read_child_rank !== want_result.read_child_rank)
					report_mismatch("read_child_rank", read_child_rank,
						want_result.read_child_rank);
			end
		end
	end

	// Ends the run when neither a command nor a result transaction has moved
	// for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done)
				quiet = 0;
			else
				quiet++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin
		arst_n       <= 1'b0;
		start        <= 1'b0;
		mode         <= tksl_pkg::MODE_INSERT;
		score        <= '0;
		rule_index   <= '0;
		child_node   <= '0;
		child_length <= '0;
		child_rank   <= '0;
		slot         <= '0;
		cfg_wr_en    <= 1'b0;
		cfg_index    <= tksl_pkg::REG_CAPACITY;
		cfg_wdata    <= '0;
		cap_setting   = tksl_pkg::CAPACITY_RESET;
		highest_first = 1'b1;
		held_total    = 0;
		mismatches    = 0;
		results_seen  = 0;
		sender_idles  = 1'b1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_order();
		test_capacity_limits();
		test_random_traffic();

		settle_list();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

@@ files.f @@
rtl/tksl_pkg.sv
rtl/tksl_ctrl.sv
rtl/tksl_dp.sv
rtl/top_k_sorted_insert_list.sv
tb/top_k_sorted_insert_list_test.sv
